FILE: hw/rtl/i2r_pkg.sv
// Shared types, letter codes and digit coding functions for the Roman numeral encoder.
`default_nettype none

package i2r_pkg;

  // Field widths.
  localparam int NumW    = 16;
  localparam int WorkW   = 12;
  localparam int LetterW = 7;
  localparam int DigitW  = 4;
  localparam int NDigits = 4;
  localparam int PosW    = 2;
  localparam int KW      = 2;
  localparam int LenW    = 3;

  // Valid input range.
  localparam logic [NumW-1:0] NumMax = 16'd3999;

  // Divide by ten through a scaled reciprocal, exact for values below 16384.
  localparam int RecipW = 13;
  localparam logic [RecipW-1:0] RecipTen = 13'd6554;
  localparam int RecipShift = 16;

  // ASCII letter codes.
  localparam logic [LetterW-1:0] ChrM = 7'h4D;
  localparam logic [LetterW-1:0] ChrD = 7'h44;
  localparam logic [LetterW-1:0] ChrC = 7'h43;
  localparam logic [LetterW-1:0] ChrL = 7'h4C;
  localparam logic [LetterW-1:0] ChrX = 7'h58;
  localparam logic [LetterW-1:0] ChrV = 7'h56;
  localparam logic [LetterW-1:0] ChrI = 7'h49;
  localparam logic [LetterW-1:0] ChrNone = 7'h00;

  // Digit positions, most significant first.
  localparam logic [PosW-1:0] PosThousands = 2'd0;
  localparam logic [PosW-1:0] PosHundreds  = 2'd1;
  localparam logic [PosW-1:0] PosTens      = 2'd2;
  localparam logic [PosW-1:0] PosUnits     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div;
    logic skip;
    logic emit;
    logic emit_err;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic err;
    logic len_zero;
    logic final_chr;
    logic slot_free;
  } sts_t;

  // Number of letters that one decimal digit turns into.
  function automatic logic [LenW-1:0] digit_len(input logic [DigitW-1:0] d);
    logic [LenW-1:0] len;
    case (d)
      4'd0: len = 3'd0;
      4'd1: len = 3'd1;
      4'd2: len = 3'd2;
      4'd3: len = 3'd3;
      4'd4: len = 3'd2;
      4'd5: len = 3'd1;
      4'd6: len = 3'd2;
      4'd7: len = 3'd3;
      4'd8: len = 3'd4;
      4'd9: len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Letter k of the digit d at position pos.
  function automatic logic [LetterW-1:0] digit_char(input logic [DigitW-1:0] d,
                                                   input logic [KW-1:0] k,
                                                   input logic [PosW-1:0] pos);
    logic [LetterW-1:0] one;
    logic [LetterW-1:0] five;
    logic [LetterW-1:0] ten;
    logic [LetterW-1:0] chr;
    case (pos)
      PosThousands: begin
        one = ChrM; five = ChrM; ten = ChrM;
      end
      PosHundreds: begin
        one = ChrC; five = ChrD; ten = ChrM;
      end
      PosTens: begin
        one = ChrX; five = ChrL; ten = ChrC;
      end
      default: begin
        one = ChrI; five = ChrV; ten = ChrX;
      end
    endcase
    if (d <= 4'd3) begin
      chr = one;
    end else if (d == 4'd4) begin
      chr = (k == '0) ? one : five;
    end else if (d <= 4'd8) begin
      chr = (k == '0) ? five : one;
    end else begin
      chr = (k == '0) ? one : ten;
    end
    return chr;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/i2r_dp.sv
// Datapath: digit split by ten, letter sequencing and the output word register.
`default_nettype none

module i2r_dp (
  input  wire                            clk,
  input  wire                            rst_n,
  input  i2r_pkg::cmd_t                  cmd,
  output i2r_pkg::sts_t                  sts,
  input  wire [i2r_pkg::NumW-1:0]        number,
  output logic [i2r_pkg::LetterW-1:0]    letter,
  output logic                           last,
  output logic                           out_of_range,
  output logic                           out_valid,
  input  wire                            out_ready
);

  localparam int ProdW = i2r_pkg::WorkW + i2r_pkg::RecipW;
  localparam int QW    = ProdW - i2r_pkg::RecipShift;

  logic [i2r_pkg::WorkW-1:0]   num_r;
  logic [i2r_pkg::DigitW-1:0]  dig_r [i2r_pkg::NDigits];
  logic [i2r_pkg::PosW-1:0]    pos_r;
  logic [i2r_pkg::KW-1:0]      k_r;
  logic                        err_r;
  logic [i2r_pkg::LetterW-1:0] letter_r;
  logic                        last_r;
  logic                        oor_r;
  logic                        out_valid_r;

  logic [ProdW-1:0]            prod;
  logic [QW-1:0]               quot;
  logic [i2r_pkg::WorkW-1:0]   quot_x10;
  logic [i2r_pkg::WorkW-1:0]   rem_full;
  logic [i2r_pkg::DigitW-1:0]  cur_dig;
  logic [i2r_pkg::LenW-1:0]    cur_len;
  logic                        last_of_digit;
  logic                        rest_zero;
  logic [i2r_pkg::LetterW-1:0] cur_chr;

  // One divide-by-ten step: quotient by reciprocal, remainder by back-multiply.
  always_comb begin
    prod     = ProdW'(num_r) * ProdW'(i2r_pkg::RecipTen);
    quot     = prod[ProdW-1:i2r_pkg::RecipShift];
    quot_x10 = i2r_pkg::WorkW'({quot, 3'b000}) + i2r_pkg::WorkW'({quot, 1'b0});
    rem_full = num_r - quot_x10;
  end

  // Current digit, its letter and whether this letter closes the numeral.
  always_comb begin
    cur_dig       = dig_r[pos_r];
    cur_len       = i2r_pkg::digit_len(cur_dig);
    last_of_digit = ({1'b0, k_r} == (cur_len - 3'd1));
    cur_chr       = i2r_pkg::digit_char(cur_dig, k_r, pos_r);
    rest_zero     = 1'b1;
    for (int i = 0; i < i2r_pkg::NDigits; i++) begin
      if (i > int'(pos_r) && dig_r[i] != '0) begin
        rest_zero = 1'b0;
      end
    end
  end

  // Work registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r <= number[i2r_pkg::WorkW-1:0];
      err_r <= (number == '0) || (number > i2r_pkg::NumMax);
      pos_r <= i2r_pkg::PosThousands;
      k_r   <= '0;
    end else if (cmd.div) begin
      num_r    <= quot_x10 == '0 ? '0 : i2r_pkg::WorkW'(quot);
      dig_r[0] <= rem_full[i2r_pkg::DigitW-1:0];
      for (int i = 1; i < i2r_pkg::NDigits; i++) begin
        dig_r[i] <= dig_r[i-1];
      end
    end else if (cmd.skip) begin
      pos_r <= pos_r + 2'd1;
      k_r   <= '0;
    end else if (cmd.emit) begin
      if (last_of_digit) begin
        pos_r <= pos_r + 2'd1;
        k_r   <= '0;
      end else begin
        k_r <= k_r + 2'd1;
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      letter_r <= cur_chr;
      last_r   <= last_of_digit && rest_zero;
      oor_r    <= 1'b0;
    end else if (cmd.emit_err) begin
      letter_r <= i2r_pkg::ChrNone;
      last_r   <= 1'b1;
      oor_r    <= 1'b1;
    end
  end

  assign sts.err       = err_r;
  assign sts.len_zero  = (cur_len == '0);
  assign sts.final_chr = last_of_digit && rest_zero;
  assign sts.slot_free = !out_valid_r || out_ready;

  assign letter       = letter_r;
  assign last         = last_r;
  assign out_of_range = oor_r;
  assign out_valid    = out_valid_r;

endmodule

`default_nettype wire

FILE: hw/rtl/i2r_ctrl.sv
// Controller: sequences load, digit split, letter emission and the range error word.
`default_nettype none

module i2r_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  i2r_pkg::sts_t  sts,
  output i2r_pkg::cmd_t  cmd
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSplit = 2'd1;
  localparam logic [1:0] StEmit  = 2'd2;
  localparam logic [1:0] StErr   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic [1:0] step_r;
  logic [1:0] step_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      StIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          step_nxt  = '0;
          state_nxt = StSplit;
        end
      end
      StSplit: begin
        if (sts.err) begin
          state_nxt = StErr;
        end else begin
          cmd.div  = 1'b1;
          step_nxt = step_r + 2'd1;
          if (step_r == 2'd3) begin
            state_nxt = StEmit;
          end
        end
      end
      StEmit: begin
        if (sts.len_zero) begin
          cmd.skip = 1'b1;
        end else if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.final_chr) begin
            state_nxt = StIdle;
          end
        end
      end
      StErr: begin
        if (sts.slot_free) begin
          cmd.emit_err = 1'b1;
          state_nxt    = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // A word is only written into a free output slot.
  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.emit_err) |-> sts.slot_free)
    else $error("word written into an occupied output slot");

  // An accepted number always starts the digit split.
  a_load_split: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == StIdle && in_valid) |=> (state_r == StSplit && step_r == 2'd0))
    else $error("accepted number did not start the split");

  // The closing letter returns the controller to idle.
  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && sts.final_chr) |=> state_r == StIdle)
    else $error("controller kept running after the closing letter");

  // The error word is only sent for an out-of-range number.
  a_err_only: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_err |-> sts.err)
    else $error("error word sent for an in-range number");

endmodule

`default_nettype wire

FILE: hw/rtl/integer_to_roman_encoder.sv
// Top level of the integer to Roman numeral encoder: controller plus datapath.
//
//  Channel | Ports                          | Word contents
//  --------+--------------------------------+--------------------------------------
//  input   | in_tvalid/in_tready/in_tdata   | tdata[15:0] number
//  output  | out_tvalid/out_tready/out_tdata| tdata[6:0] letter, tdata[7] zero,
//          | out_tlast/out_tuser            | tlast last, tuser[0] out_of_range
//
// A number is taken, then split into four decimal digits one after another by a
// shared divide-by-ten unit; then one letter is sent per cycle while the output
// is not stalled, with a skip step for each zero digit ahead of the last nonzero
// one. An out-of-range number skips the split and sends one flagged word instead.
// Output stalls hold the letter sequence; the last letter sits in the output
// register while the next number is accepted. Reset clears control state only.
`default_nettype none

module integer_to_roman_encoder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [15:0] number
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [6:0] letter, [7] zero fill
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] out_of_range
);

  i2r_pkg::cmd_t               cmd;
  i2r_pkg::sts_t               sts;
  logic [i2r_pkg::LetterW-1:0] letter;
  logic                        oor;

  i2r_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2r_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .number       (in_tdata),
    .letter       (letter),
    .last         (out_tlast),
    .out_of_range (oor),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready)
  );

  assign out_tdata = {1'b0, letter};
  assign out_tuser = oor;

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// Self-checking testbench for the integer to Roman numeral encoder.
`timescale 1ns / 100ps

module tb_top;

  // ASCII codes of the numeral letters.
  localparam logic [6:0] LtrM = 7'h4D;
  localparam logic [6:0] LtrD = 7'h44;
  localparam logic [6:0] LtrC = 7'h43;
  localparam logic [6:0] LtrL = 7'h4C;
  localparam logic [6:0] LtrX = 7'h58;
  localparam logic [6:0] LtrV = 7'h56;
  localparam logic [6:0] LtrI = 7'h49;
  localparam logic [6:0] LtrNone = 7'h00;

  localparam int MaxNumeral = 3999;
  localparam int RandomNumbers = 380;
  localparam int CycleLimit = 400000;
  localparam int SettleCycles = 60;

  // Receiver stall patterns.
  typedef enum logic [1:0] {
    ReadyAlways,
    ReadyCoin,
    ReadySparse,
    ReadyPeriodic
  } ready_style_t;

  // One number waiting to be sent; drain_first holds it back until all letters are out.
  typedef struct {
    logic [15:0] value;
    bit          drain_first;
  } number_item_t;

  // One expected output word.
  typedef struct packed {
    logic [15:0] number;
    logic [6:0]  letter;
    logic        last;
    logic        out_of_range;
  } numeral_char_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = 16'd0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  number_item_t  numbers_pending[$];
  numeral_char_t letters_due[$];

  int           cycle_count = 0;
  bit           number_taken = 1'b0;
  int           burst_left = 1;
  int           gap_left = 0;
  ready_style_t ready_style = ReadyAlways;
  int           ready_run = 0;

  int fault_count = 0;
  int numbers_encoded = 0;
  int out_of_range_count = 0;
  int letters_checked = 0;
  int longest_numeral = 0;

  integer_to_roman_encoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count a failure; only the first few are printed in full.
  task automatic note_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) begin
      $display("cycle %0d: %s", cycle_count, msg);
    end
  endtask

  // Queue one ordinary letter of the numeral for the given number.
  task automatic queue_letter(input logic [15:0] number, input logic [6:0] letter);
    numeral_char_t word;
    word = '{number: number, letter: letter, last: 1'b0, out_of_range: 1'b0};
    letters_due = {letters_due, word};
  endtask

  // Letters for one decimal digit, given the one, five and ten letters of its position.
  task automatic queue_digit(input logic [15:0] number, input int d,
                             input logic [6:0] one, input logic [6:0] five,
                             input logic [6:0] ten);
    if (d == 9) begin
      queue_letter(number, one);
      queue_letter(number, ten);
    end else if (d >= 4) begin
      if (d == 4) begin
        queue_letter(number, one);
      end
      queue_letter(number, five);
      for (int i = 5; i < d; i++) begin
        queue_letter(number, one);
      end
    end else begin
      for (int i = 0; i < d; i++) begin
        queue_letter(number, one);
      end
    end
  endtask

  // Expected letters of the numeral for one accepted number.
  task automatic predict_numeral(input logic [15:0] number);
    int rest;
    int first;
    int len;
    numeral_char_t err_word;
    first = letters_due.size();
    numbers_encoded++;
    if (number == 16'd0 || number > MaxNumeral) begin
      // Zero or too large: one flagged word with no letter.
      err_word = '{number: number, letter: LtrNone, last: 1'b1, out_of_range: 1'b1};
      letters_due = {letters_due, err_word};
      out_of_range_count++;
    end else begin
      rest = number;
      queue_digit(number, rest / 1000, LtrM, LtrM, LtrM);
      queue_digit(number, (rest / 100) % 10, LtrC, LtrD, LtrM);
      queue_digit(number, (rest / 10) % 10, LtrX, LtrL, LtrC);
      queue_digit(number, rest % 10, LtrI, LtrV, LtrX);
      letters_due[letters_due.size() - 1].last = 1'b1;
      len = letters_due.size() - first;
      if (len > longest_numeral) begin
        longest_numeral = len;
      end
    end
  endtask

  // Monitor: predicts on each accepted number and checks each accepted letter.
  always @(posedge clk) begin : monitor
    numeral_char_t want;
    cycle_count <= cycle_count + 1;
    number_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      predict_numeral(in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      letters_checked++;
      if (letters_due.size() == 0) begin
        note_fault($sformatf("unexpected word tdata=%h tlast=%b tuser=%b",
                             out_tdata, out_tlast, out_tuser));
      end else begin
        want = letters_due.pop_front();
        if (out_tdata !== {1'b0, want.letter}) begin
          note_fault($sformatf("number %0d: letter expected %h got %h",
                               want.number, {1'b0, want.letter}, out_tdata));
        end
        if (out_tlast !== want.last) begin
          note_fault($sformatf("number %0d: last expected %b got %b",
                               want.number, want.last, out_tlast));
        end
        if (out_tuser[0] !== want.out_of_range) begin
          note_fault($sformatf("number %0d: out_of_range expected %b got %b",
                               want.number, want.out_of_range, out_tuser[0]));
        end
      end
    end
    // Give up if the run hangs.
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d letters still expected", letters_due.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Driver: sends queued numbers in bursts with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !number_taken) begin
      // Word not yet taken; hold it.
    end else if (gap_left != 0) begin
      gap_left <= gap_left - 1;
      in_tvalid <= 1'b0;
      in_tdata <= 16'($urandom);
    end else if (numbers_pending.size() != 0 &&
                 !(numbers_pending[0].drain_first && letters_due.size() != 0)) begin
      in_tvalid <= 1'b1;
      in_tdata <= numbers_pending[0].value;
      numbers_pending.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_tvalid <= 1'b0;
      in_tdata <= 16'($urandom);
    end
  end

  // Receiver: switches at random between stall patterns.
  always @(negedge clk) begin
    if (ready_run == 0) begin
      ready_style <= ready_style_t'($urandom_range(0, 3));
      ready_run <= $urandom_range(16, 96);
    end else begin
      ready_run <= ready_run - 1;
    end
    case (ready_style)
      ReadyAlways: out_tready <= 1'b1;
      ReadyCoin: out_tready <= 1'($urandom_range(0, 1));
      ReadySparse: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (cycle_count[2] == 1'b1);
    endcase
  end

  // Stimulus, reset and end of run.
  initial begin : stimulus
    int directed[$];
    int pick;
    logic [15:0] value;
    number_item_t item;
    // Extremes, every digit shape, skipped zero digits and out-of-range values.
    directed = '{0, 1, 4, 5, 8, 9, 10, 40, 49, 90, 100, 400, 900, 999, 1000, 1001,
                 3000, 3004, 3888, 3999, 4000, 16384, 32768, 65535};
    foreach (directed[i]) begin
      // Let everything drain once before 3999, the largest valid number, is sent.
      item = '{value: 16'(directed[i]), drain_first: (directed[i] == 3999)};
      numbers_pending = {numbers_pending, item};
    end
    for (int i = 0; i < RandomNumbers; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        value = 16'd0;
      end else if (pick <= 2) begin
        value = 16'($urandom_range(MaxNumeral + 1, 65535));
      end else if (pick <= 4) begin
        value = 16'($urandom_range(1, 50));
      end else begin
        value = 16'($urandom_range(1, MaxNumeral));
      end
      item = '{value: value, drain_first: (i % 95 == 94)};
      numbers_pending = {numbers_pending, item};
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait until every number has been taken, then until every letter is out.
    while (numbers_pending.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
    while (letters_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (SettleCycles) @(posedge clk);

    $display("Encoded %0d numbers (%0d out of range) into %0d checked words.",
             numbers_encoded, out_of_range_count, letters_checked);
    $display("Longest numeral %0d letters; %0d faults found.", longest_numeral, fault_count);
    if (fault_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
